### hdl/pdw_pkg.sv
package pdw_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // Register index of the distance offset (paddr bit 2).
  localparam logic REG_DISTANCE_OFFSET = 1'b0;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        point_id;
    logic signed [31:0] point_distance;
    logic signed [31:0] point_elevation;
    logic signed [31:0] water_level;
    logic signed [31:0] query_distance;
  } item_t;

  typedef struct packed {
    logic signed [31:0] depth;
    logic               depth_valid;
    logic signed [31:0] left_edge;
    logic               left_valid;
    logic [15:0]        left_outer_id;
    logic signed [31:0] right_edge;
    logic               right_valid;
    logic [15:0]        right_outer_id;
  } result_t;

  // One stored point of the profile.
  typedef struct packed {
    logic [15:0]        id;
    logic signed [31:0] distance;
    logic signed [31:0] elev;
  } point_t;

  // Interpolation job: a0 + (a1 - a0) * num / den, truncated toward a0.
  typedef struct packed {
    logic signed [31:0] a0;
    logic signed [31:0] a1;
    logic [32:0]        num;
    logic [32:0]        den;
  } interp_req_t;

endpackage

### hdl/pdw_interp.sv
module pdw_interp (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pdw_pkg::interp_req_t req,
  output logic                done,
  output logic signed [31:0]  res
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;

  state_t             state;
  logic signed [31:0] a0;
  logic               neg;
  logic [32:0]        mag;
  logic [32:0]        num_sh;
  logic [32:0]        den;
  logic [65:0]        acc;
  logic [65:0]        acc_next;
  logic [32:0]        rem;
  logic [32:0]        low;
  logic [32:0]        q;
  logic [5:0]         cnt;
  logic signed [32:0] diff;
  logic [33:0]        trial;
  logic [33:0]        trial_sub;
  logic               ge;
  logic [33:0]        sum;

  // End-point difference, one shift-add product step, divide trial and sum.
  always_comb begin
    diff      = {req.a1[31], req.a1} - {req.a0[31], req.a0};
    acc_next  = {acc[64:0], 1'b0} + (num_sh[32] ? {33'b0, mag} : 66'b0);
    trial     = {rem, low[32]};
    trial_sub = trial - {1'b0, den};
    ge        = (trial >= {1'b0, den});
    sum       = neg ? ({a0[31], a0[31], a0} - {1'b0, q})
                    : ({a0[31], a0[31], a0} + {1'b0, q});
  end

  // Serial multiply, then restoring divide; q is at most mag if num <= den.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            a0     <= req.a0;
            neg    <= diff[32];
            mag    <= diff[32] ? 33'(-diff) : 33'(diff);
            num_sh <= req.num;
            den    <= req.den;
            acc    <= '0;
            cnt    <= '0;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          acc    <= acc_next;
          num_sh <= {num_sh[31:0], 1'b0};
          cnt    <= cnt + 6'd1;
          if (cnt == 6'd32) begin
            rem   <= acc_next[65:33];
            low   <= acc_next[32:0];
            q     <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= ge ? trial_sub[32:0] : trial[32:0];
          low <= {low[31:0], 1'b0};
          q   <= {q[31:0], ge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd32) state <= S_FIN;
        end
        S_FIN: begin
          res   <= sum[31:0];
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/profile_depth_and_waterline.sv
// River cross-section profile with depth and shoreline queries.
// Items enter on the command port: an item is taken at a clock edge with
// start high and busy low. A clear or an append finishes in the cycle it
// is taken and busy stays low. A query raises busy, which falls in the
// same cycle as result_valid, high for exactly one cycle, marks its result.
// The receiver cannot stall; a result must be taken in its cycle.
// A query makes one forward pass and one backward pass over the n stored
// points through the single read port of the point memory, then up to
// three interpolations in a shared serial multiply/divide unit. Queries
// run one at a time.
// The distance offset is written over the APB port at byte address 0.
// Reset empties the table and zeroes the offset; memory contents are not
// cleared, since only entries below the point count are ever read.
module profile_depth_and_waterline #(
  parameter int MAX_POINTS = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pdw_pkg::item_t   item,
  output logic             result_valid,
  output pdw_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_POINTS);

  typedef enum logic [2:0] {S_IDLE, S_FWD, S_BWD, S_ISSUE, S_WAIT, S_OUT} state_t;

  state_t               state;
  logic signed [31:0]   distance_offset;
  logic [CW-1:0]        point_count;
  pdw_pkg::point_t      mem [MAX_POINTS];
  pdw_pkg::point_t      rd_data;
  logic [AW-1:0]        rd_addr;
  logic                 rd_en;
  logic [CW-1:0]        ia;
  logic                 rv;
  logic [CW-1:0]        di;
  pdw_pkg::point_t      prev;
  logic signed [31:0]   water;
  logic signed [31:0]   off;
  logic                 dep_found, left_found, right_found;
  logic                 dep_ok, left_ok, right_ok;
  pdw_pkg::interp_req_t dep_req, left_req, right_req, ip_req;
  logic [15:0]          left_id, right_id;
  logic [1:0]           idx;
  logic                 ip_start, ip_done;
  logic signed [31:0]   ip_res;
  logic                 sel_ok;
  logic signed [32:0]   off_sum;
  logic signed [31:0]   off_sat;
  logic signed [32:0]   depth_diff;
  logic signed [31:0]   depth_sat;
  logic                 take;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign busy   = (state != S_IDLE);
  assign take   = start && !busy;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == pdw_pkg::REG_DISTANCE_OFFSET);
  assign prdata = (paddr[2] == pdw_pkg::REG_DISTANCE_OFFSET) ? distance_offset : 32'd0;

  // Shifted query distance, saturated, and the depth saturation.
  always_comb begin
    off_sum = {item.query_distance[31], item.query_distance}
            + {distance_offset[31], distance_offset};
    if (off_sum[32] != off_sum[31]) off_sat = off_sum[32] ? 32'sh80000000 : 32'sh7fffffff;
    else off_sat = off_sum[31:0];
    depth_diff = {water[31], water} - {ip_res[31], ip_res};
    if (depth_diff[32] != depth_diff[31])
      depth_sat = depth_diff[32] ? 32'sh80000000 : 32'sh7fffffff;
    else depth_sat = depth_diff[31:0];
  end

  // Read address for the scans.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ia[AW-1:0];
    if (state == S_FWD && ia < point_count) rd_en = 1'b1;
    if (state == S_BWD && ia != '0) begin
      rd_en   = 1'b1;
      rd_addr = AW'(ia - CW'(1));
    end
  end

  // Interpolation job for the current slot.
  always_comb begin
    case (idx)
      2'd0:    begin ip_req = dep_req;   sel_ok = dep_ok;   end
      2'd1:    begin ip_req = left_req;  sel_ok = left_ok;  end
      default: begin ip_req = right_req; sel_ok = right_ok; end
    endcase
  end

  // Point memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (take && item.kind == pdw_pkg::KIND_APPEND && point_count < CAP)
      mem[point_count[AW-1:0]] <= '{id: item.point_id, distance: item.point_distance,
                                    elev: item.point_elevation};
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) distance_offset <= '0;
    else if (cfg_wr) distance_offset <= pwdata;
  end

  // Control: table updates, two scans, interpolation sequence, result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      point_count  <= '0;
      result_valid <= 1'b0;
      ip_start     <= 1'b0;
      rv           <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      ip_start     <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (take) begin
            case (item.kind)
              pdw_pkg::KIND_CLEAR: point_count <= '0;
              pdw_pkg::KIND_APPEND: begin
                if (point_count < CAP) point_count <= point_count + CW'(1);
              end
              pdw_pkg::KIND_QUERY: begin
                water       <= item.water_level;
                off         <= off_sat;
                result      <= '0;
                dep_found   <= 1'b0;
                left_found  <= 1'b0;
                right_found <= 1'b0;
                dep_ok      <= 1'b0;
                left_ok     <= 1'b0;
                right_ok    <= 1'b0;
                ia          <= '0;
                rv          <= 1'b0;
                state       <= S_FWD;
              end
              default: ;
            endcase
          end
        end
        S_FWD: begin
          rv <= rd_en;
          di <= ia;
          if (rd_en) ia <= ia + CW'(1);
          if (rv) begin
            prev <= rd_data;
            if (!dep_found && rd_data.distance >= off) begin
              dep_found <= 1'b1;
              if (di != '0) begin
                dep_ok  <= 1'b1;
                dep_req <= '{a0: prev.elev, a1: rd_data.elev,
                  num: 33'({off[31], off} - {prev.distance[31], prev.distance}),
                  den: 33'({rd_data.distance[31], rd_data.distance}
                           - {prev.distance[31], prev.distance})};
              end
            end
            if (!left_found && rd_data.elev <= water) begin
              left_found <= 1'b1;
              if (di != '0) begin
                left_ok  <= 1'b1;
                left_id  <= prev.id;
                left_req <= '{a0: prev.distance, a1: rd_data.distance,
                  num: 33'({prev.elev[31], prev.elev} - {water[31], water}),
                  den: 33'({prev.elev[31], prev.elev} - {rd_data.elev[31], rd_data.elev})};
              end
            end
          end
          if (!rd_en && !rv) begin
            ia    <= point_count;
            state <= S_BWD;
          end
        end
        S_BWD: begin
          rv <= rd_en;
          di <= ia - CW'(1);
          if (rd_en) ia <= ia - CW'(1);
          if (rv) begin
            prev <= rd_data;
            if (!right_found && rd_data.elev <= water) begin
              right_found <= 1'b1;
              if (di != point_count - CW'(1)) begin
                right_ok  <= 1'b1;
                right_id  <= prev.id;
                right_req <= '{a0: prev.distance, a1: rd_data.distance,
                  num: 33'({prev.elev[31], prev.elev} - {water[31], water}),
                  den: 33'({prev.elev[31], prev.elev} - {rd_data.elev[31], rd_data.elev})};
              end
            end
          end
          if (!rd_en && !rv) begin
            idx   <= 2'd0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (sel_ok) begin
            ip_start <= 1'b1;
            state    <= S_WAIT;
          end else if (idx == 2'd2) begin
            state <= S_OUT;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        S_WAIT: begin
          if (ip_done) begin
            case (idx)
              2'd0: begin
                result.depth       <= depth_sat;
                result.depth_valid <= 1'b1;
              end
              2'd1: begin
                result.left_edge     <= ip_res;
                result.left_valid    <= 1'b1;
                result.left_outer_id <= left_id;
              end
              default: begin
                result.right_edge     <= ip_res;
                result.right_valid    <= 1'b1;
                result.right_outer_id <= right_id;
              end
            endcase
            if (idx == 2'd2) state <= S_OUT;
            else begin
              idx   <= idx + 2'd1;
              state <= S_ISSUE;
            end
          end
        end
        S_OUT: begin
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  pdw_interp u_interp (
    .clk   (clk),
    .rst   (rst),
    .start (ip_start),
    .req   (ip_req),
    .done  (ip_done),
    .res   (ip_res)
  );

endmodule
